@@ rtl/core/epso_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso_pkg
// Shared types, constants and elaboration-time table builders for the
// exponential-pitch sine oscillator.
// ----------------------------------------------------------------------------
package epso_pkg;

	localparam int CV_W       = 17;
	localparam int OFFSET_W   = 13;
	localparam int INC_W      = 32;
	localparam int SAMPLE_W   = 16;
	localparam int AMP_W      = 15;
	localparam int FACTOR_W   = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int PITCH_W    = 18;
	localparam int OCT_W      = 4;
	localparam int FRAC_W     = 12;

	localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = 18'sd16384;

	localparam logic [OFFSET_W-1:0] PITCH_OFFSET_RST = 13'd0;
	localparam logic [INC_W-1:0]    BASE_INC_RST     = 32'd25480118;
	localparam logic [INC_W-1:0]    BLINK_INC_RST    = 32'd97392;

	localparam logic [63:0] SIN_C0 = 64'd1686629713;
	localparam logic [63:0] SIN_C1 = 64'd693598669;
	localparam logic [63:0] SIN_C2 = 64'd85569306;
	localparam logic [63:0] SIN_C3 = 64'd5026995;
	localparam logic [63:0] SIN_C4 = 64'd172272;
	localparam logic [63:0] FULL_SCALE = 64'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_OFFSET = 2'd0,
		REG_BASE_INC     = 2'd1,
		REG_BLINK_INC    = 2'd2
	} cfg_reg_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] w;
		r = 64'd0;
		b = 64'd1 << 62;
		w = v;
		while (b > w) b = b >> 2;
		while (b != 64'd0) begin
			if (w >= r + b) begin
				w = w - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Q30 value of 2^(q / 2^ebits), built from chained square roots of two
	function automatic logic [FACTOR_W-1:0] exp2_factor(int unsigned q, int unsigned ebits);
		logic [63:0] root [13];
		logic [63:0] m;
		int j;
		root[0] = 64'd2 << 30;
		for (j = 1; j <= 12; j++) root[j] = isqrt64(root[j-1] << 30);
		m = 64'd1 << 30;
		for (j = 1; j <= int'(ebits); j++) begin
			if (((q >> (int'(ebits) - j)) & 1) != 0) m = (m * root[j]) >> 30;
		end
		return m[FACTOR_W-1:0];
	endfunction

	// quarter-wave amplitude for step r of a quadrant split in 2^(sbits-2) steps
	function automatic logic [AMP_W-1:0] sine_amp(int unsigned r, int unsigned sbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] s;
		logic [63:0] amp;
		x   = 64'(r) << (30 - (int'(sbits) - 2));
		x2  = (x * x) >> 30;
		acc = SIN_C4;
		acc = SIN_C3 - ((x2 * acc) >> 30);
		acc = SIN_C2 - ((x2 * acc) >> 30);
		acc = SIN_C1 - ((x2 * acc) >> 30);
		acc = SIN_C0 - ((x2 * acc) >> 30);
		s   = (x * acc) >> 30;
		amp = (s * FULL_SCALE + (64'd1 << 29)) >> 30;
		if (amp > FULL_SCALE) amp = FULL_SCALE;
		return amp[AMP_W-1:0];
	endfunction

endpackage

@@ rtl/core/epso_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso channel interfaces
// Pitch input, sample output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface epso_pitch_if import epso_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [CV_W-1:0] pitch_cv;

	modport source(output valid, pitch_cv, input ready);
	modport sink(input valid, pitch_cv, output ready);
endinterface

interface epso_sample_if import epso_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sine_sample;
	logic signed [SAMPLE_W-1:0] double_sine_sample;
	logic                       light_on;

	modport source(output valid, sine_sample, double_sine_sample, light_on, input ready);
	modport sink(input valid, sine_sample, double_sine_sample, light_on, output ready);
endinterface

interface epso_cfg_if import epso_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/epso_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso_cfg_regs
// Register file for pitch offset, base increment and blink increment.
// ----------------------------------------------------------------------------
module epso_cfg_regs import epso_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic                  wr_ready,
	output logic [OFFSET_W-1:0]   pitch_offset,
	output logic [INC_W-1:0]      base_increment,
	output logic [INC_W-1:0]      blink_increment
);

	logic [OFFSET_W-1:0] pitch_offset_q;
	logic [INC_W-1:0]    base_inc_q;
	logic [INC_W-1:0]    blink_inc_q;

	assign wr_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_offset_q <= PITCH_OFFSET_RST;
			base_inc_q     <= BASE_INC_RST;
			blink_inc_q    <= BLINK_INC_RST;
		end else if (wr_valid) begin
			unique case (cfg_reg_t'(wr_index))
				REG_PITCH_OFFSET: pitch_offset_q <= wr_data[OFFSET_W-1:0];
				REG_BASE_INC:     base_inc_q     <= wr_data[INC_W-1:0];
				REG_BLINK_INC:    blink_inc_q    <= wr_data[INC_W-1:0];
				default: ;
			endcase
		end
	end

	assign pitch_offset    = pitch_offset_q;
	assign base_increment  = base_inc_q;
	assign blink_increment = blink_inc_q;

endmodule

@@ rtl/core/epso_inc_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso_inc_pipe
// Pitch to phase increment: clamp, exp2 fraction table, multiply, octave shift.
// ----------------------------------------------------------------------------
module epso_inc_pipe import epso_pkg::*; #(
	parameter int PHASE_BITS     = 32,
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic signed [CV_W-1:0] pitch_cv,
	input  logic [OFFSET_W-1:0]    pitch_offset,
	input  logic [INC_W-1:0]       base_increment,
	output logic                   inc_valid,
	output logic [PHASE_BITS-1:0]  inc
);

	localparam int EXP_SIZE = 1 << EXP_TABLE_BITS;
	localparam int PROD_W   = INC_W + FACTOR_W;
	localparam int PRE_W    = PROD_W - 30;
	localparam int SH_W     = PRE_W + 8;

	logic [FACTOR_W-1:0] exp_rom [EXP_SIZE];

	for (genvar g = 0; g < EXP_SIZE; g++) begin : g_exp_rom
		assign exp_rom[g] = exp2_factor(g, EXP_TABLE_BITS);
	end

	logic                      v_s1, v_s2, v_s3;
	logic signed [CV_W-1:0]    pitch_cv_s1;
	logic [FACTOR_W-1:0]       factor_s2;
	logic [OCT_W-1:0]          oct_s2, oct_s3;
	logic [PRE_W-1:0]          inc_pre_s3;

	logic signed [PITCH_W-1:0] pitch_sum;
	logic signed [PITCH_W-1:0] pitch_clamp;
	logic [PITCH_W-1:0]        pitch_u;
	logic [PROD_W-1:0]         prod;
	logic [SH_W-1:0]           shifted;
	logic [INC_W-1:0]          inc32;

	always_comb begin
		pitch_sum = $signed(PITCH_W'({1'b0, pitch_offset})) + PITCH_W'(pitch_cv_s1);
		if (pitch_sum > PITCH_LIMIT)
			pitch_clamp = PITCH_LIMIT;
		else if (pitch_sum < -PITCH_LIMIT)
			pitch_clamp = -PITCH_LIMIT;
		else
			pitch_clamp = pitch_sum;
		pitch_u = PITCH_W'(pitch_clamp + PITCH_LIMIT);
	end

	assign prod    = PROD_W'(base_increment) * PROD_W'(factor_s2);
	assign shifted = SH_W'(inc_pre_s3) << oct_s3;
	assign inc32   = shifted[INC_W+3:4];

	if (PHASE_BITS >= INC_W) begin : g_align_up
		assign inc = PHASE_BITS'(inc32) << (PHASE_BITS - INC_W);
	end else begin : g_align_down
		assign inc = inc32[INC_W-1 -: PHASE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_cv_s1 <= pitch_cv;
			factor_s2   <= exp_rom[pitch_u[FRAC_W-1 -: EXP_TABLE_BITS]];
			oct_s2      <= pitch_u[FRAC_W+OCT_W-1:FRAC_W];
			inc_pre_s3  <= prod[PROD_W-1:30];
			oct_s3      <= oct_s2;
		end
	end

	assign inc_valid = v_s3;

endmodule

@@ rtl/core/epso_phase_out.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso_phase_out
// Phase and blink accumulators, quarter-wave sine lookup, result register.
// ----------------------------------------------------------------------------
module epso_phase_out import epso_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       inc_valid,
	input  logic [PHASE_BITS-1:0]      inc,
	input  logic [INC_W-1:0]           blink_increment,
	input  logic                       out_ready,
	output logic                       adv,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] sine_sample,
	output logic signed [SAMPLE_W-1:0] double_sine_sample,
	output logic                       light_on
);

	localparam int R_W   = SINE_TABLE_BITS - 2;
	localparam int IDX_W = SINE_TABLE_BITS - 1;
	localparam int QSIZE = 1 << R_W;

	logic [AMP_W-1:0] sine_rom [QSIZE+1];

	for (genvar g = 0; g <= QSIZE; g++) begin : g_sine_rom
		assign sine_rom[g] = sine_amp(g, SINE_TABLE_BITS);
	end

	logic                       v_s4;
	logic                       out_valid_q;
	logic [PHASE_BITS-1:0]      osc_phase_q;
	logic [INC_W-1:0]           blink_phase_q;
	logic signed [SAMPLE_W-1:0] sine_q, dsine_q;
	logic                       light_q;

	logic [SINE_TABLE_BITS-1:0] k    [2];
	logic [IDX_W-1:0]           idx  [2];
	logic [AMP_W-1:0]           amp  [2];
	logic signed [SAMPLE_W-1:0] samp [2];

	assign adv = !out_valid_q || out_ready;

	assign k[0] = osc_phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign k[1] = osc_phase_q[PHASE_BITS-2 -: SINE_TABLE_BITS];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (k[i][R_W])
				idx[i] = IDX_W'(QSIZE) - IDX_W'(k[i][R_W-1:0]);
			else
				idx[i] = IDX_W'(k[i][R_W-1:0]);
			amp[i] = sine_rom[idx[i]];
			if (k[i][SINE_TABLE_BITS-1])
				samp[i] = -$signed({1'b0, amp[i]});
			else
				samp[i] = $signed({1'b0, amp[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4          <= 1'b0;
			out_valid_q   <= 1'b0;
			osc_phase_q   <= '0;
			blink_phase_q <= '0;
		end else if (adv) begin
			v_s4        <= inc_valid;
			out_valid_q <= v_s4;
			if (inc_valid) begin
				osc_phase_q   <= osc_phase_q + inc;
				blink_phase_q <= blink_phase_q + blink_increment;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s4) begin
			sine_q  <= samp[0];
			dsine_q <= samp[1];
			light_q <= !blink_phase_q[INC_W-1];
		end
	end

	assign out_valid          = out_valid_q;
	assign sine_sample        = sine_q;
	assign double_sine_sample = dsine_q;
	assign light_on           = light_q;

endmodule

@@ rtl/core/exp_pitch_sine_oscillator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_pitch_sine_oscillator_unit
// Exponential-pitch sine oscillator with doubled-phase sine and blink light.
// ----------------------------------------------------------------------------
// Takes one pitch beat per clock and returns one sample beat for each, in
// order. A beat passes five register stages (input register, exp2 table
// read, increment multiply, phase accumulate, sine table read) before its
// sample is valid. Throughput is one beat per cycle; every stage advances
// together whenever the result register is empty or its beat is taken this
// cycle, so a stalled output stalls the input. Register writes are always
// accepted and must only be issued while no beats are in flight.
module exp_pitch_sine_oscillator_unit import epso_pkg::*; #(
	parameter int PHASE_BITS      = 32,
	parameter int SINE_TABLE_BITS = 10,
	parameter int EXP_TABLE_BITS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	epso_pitch_if.sink     pitch,
	epso_sample_if.source  sample,
	epso_cfg_if.sink       cfg
);

	logic [OFFSET_W-1:0]   pitch_offset;
	logic [INC_W-1:0]      base_increment;
	logic [INC_W-1:0]      blink_increment;
	logic                  adv;
	logic                  inc_valid;
	logic [PHASE_BITS-1:0] inc;

	epso_cfg_regs u_cfg_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_valid        (cfg.valid),
		.wr_index        (cfg.index),
		.wr_data         (cfg.data),
		.wr_ready        (cfg.ready),
		.pitch_offset    (pitch_offset),
		.base_increment  (base_increment),
		.blink_increment (blink_increment)
	);

	epso_inc_pipe #(
		.PHASE_BITS     (PHASE_BITS),
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_inc_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_valid       (pitch.valid),
		.pitch_cv       (pitch.pitch_cv),
		.pitch_offset   (pitch_offset),
		.base_increment (base_increment),
		.inc_valid      (inc_valid),
		.inc            (inc)
	);

	epso_phase_out #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_phase_out (
		.clk                (clk),
		.arst_n             (arst_n),
		.inc_valid          (inc_valid),
		.inc                (inc),
		.blink_increment    (blink_increment),
		.out_ready          (sample.ready),
		.adv                (adv),
		.out_valid          (sample.valid),
		.sine_sample        (sample.sine_sample),
		.double_sine_sample (sample.double_sine_sample),
		.light_on           (sample.light_on)
	);

	assign pitch.ready = adv;

endmodule

@@ rtl/core/epso_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epso_checker
// Port-level checks for the oscillator, bound to the top level.
// ----------------------------------------------------------------------------
module epso_checker import epso_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] sine_sample,
	input logic signed [SAMPLE_W-1:0] double_sine_sample,
	input logic                       light_on,
	input logic                       cfg_valid,
	input logic                       cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sample beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sine_sample) && $stable(double_sine_sample)
			&& $stable(light_on))
		else $error("sample payload changed while stalled");

	a_no_neg_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sine_sample != 16'sh8000 && double_sine_sample != 16'sh8000)
		else $error("sample outside symmetric range");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write not accepted");

endmodule

bind exp_pitch_sine_oscillator_unit epso_checker u_epso_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_ready           (pitch.ready),
	.out_valid          (sample.valid),
	.out_ready          (sample.ready),
	.sine_sample        (sample.sine_sample),
	.double_sine_sample (sample.double_sine_sample),
	.light_on           (sample.light_on),
	.cfg_valid          (cfg.valid),
	.cfg_ready          (cfg.ready)
);
